// ----- hdl/sle_pkg.sv -----
// ---------------------------------------------------------------------------
// sle_pkg: shared types and constants for the sequential list engine
// Holds list sizing, field types, opcodes, status codes, controller states
// and the command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package sle_pkg;

	// List sizing
	localparam int DEPTH = 128;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	// wide enough for position and count compares with one spare bit
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_LOCATE = 3'd4,
		OP_INSERT = 3'd5,
		OP_DELETE = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    res_init;
		status_t res_status;
		logic    clr_count;
		logic    wr_tail;
		logic    wr_pos;
		logic    rd_pos;
		logic    cap_read;
		logic    scan_init;
		logic    scan_step;
		logic    scan_fin;
		logic    out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    pos_ok;
		logic    ins_ok;
		logic    scan_end;
	} dp_stat_t;

endpackage

// ----- hdl/sle_ram.sv -----
// ---------------------------------------------------------------------------
// sle_ram: generic simple dual-port RAM
// One write port and one read port per cycle, read data registered.
// ---------------------------------------------------------------------------
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/sle_dp.sv -----
// ---------------------------------------------------------------------------
// sle_dp: list engine datapath
// Holds the element RAM, the count, the latched transaction, the scan
// pointer used by locate, insert and delete, and the output register.
// ---------------------------------------------------------------------------
module sle_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sle_pkg::cmd_t     cmd,
	output sle_pkg::dp_stat_t stat,
	input  logic [2:0]        opcode,
	input  sle_pkg::pos_t     position,
	input  sle_pkg::val_t     value,
	output sle_pkg::status_t  status,
	output sle_pkg::val_t     read_value,
	output sle_pkg::pos_t     found_position,
	output sle_pkg::pos_t     list_length
);
	import sle_pkg::*;

	opcode_t op_q;
	pos_t    pos_q;
	val_t    val_q;
	cnt_t    count_q;
	idx_t    ptr_q;
	cnt_t    rem_q;
	logic    hit_q;
	logic    rvld_s1;
	idx_t    raddr_s1;
	status_t status_q;
	val_t    rdval_q;
	pos_t    found_q;
	status_t out_status_q;
	val_t    out_rdval_q;
	pos_t    out_found_q;
	pos_t    out_len_q;

	cmp_t    pos_w;
	cmp_t    cnt_w;
	idx_t    pos_idx;
	logic    hit_now;
	logic    issue;
	logic    shift_wr;
	logic    ram_we;
	idx_t    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic    ram_re;
	idx_t    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	// Decode position checks against the current count
	assign pos_w   = CMP_W'(pos_q);
	assign cnt_w   = CMP_W'(count_q);
	assign pos_idx = IDX_W'(pos_w - CMP_W'(1));

	assign stat.op       = op_q;
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
	assign stat.ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign stat.scan_end = !rvld_s1 && ((rem_q == '0) || hit_q);

	// Scan control: compare returning data, issue the next read
	assign hit_now  = rvld_s1 && (op_q == OP_LOCATE) && (val_t'(ram_rdata) == val_q);
	assign issue    = cmd.scan_step && (rem_q != '0) && !hit_q && !hit_now;
	assign shift_wr = cmd.scan_step && rvld_s1 &&
		((op_q == OP_INSERT) || (op_q == OP_DELETE));

	// RAM port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		priority if (cmd.wr_tail) begin
			ram_we = 1'b1;
		end else if (cmd.wr_pos) begin
			ram_we    = 1'b1;
			ram_waddr = pos_idx;
		end else if (shift_wr) begin
			ram_we    = 1'b1;
			ram_waddr = (op_q == OP_INSERT) ? raddr_s1 + IDX_W'(1) : raddr_s1 - IDX_W'(1);
			ram_wdata = ram_rdata;
		end else if (cmd.scan_fin && (op_q == OP_INSERT)) begin
			ram_we    = 1'b1;
			ram_waddr = pos_idx;
		end else begin
			ram_we = 1'b0;
		end
		priority if (cmd.rd_pos) begin
			ram_re    = 1'b1;
			ram_raddr = pos_idx;
		end else if (issue) begin
			ram_re = 1'b1;
		end else begin
			ram_re = 1'b0;
		end
	end

	sle_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control registers: count and read-pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= issue;
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.wr_tail) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.scan_fin && (op_q == OP_INSERT)) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.scan_fin && (op_q == OP_DELETE)) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Payload registers: transaction, scan pointer, results
	always_ff @(posedge clk) begin
		raddr_s1 <= ptr_q;
		if (cmd.load) begin
			op_q  <= opcode_t'(opcode);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.res_init) begin
			status_q <= cmd.res_status;
			rdval_q  <= '0;
			found_q  <= '0;
		end
		if (cmd.cap_read) begin
			rdval_q <= val_t'(ram_rdata);
		end
		// set the scan range per operation
		if (cmd.scan_init) begin
			hit_q <= 1'b0;
			unique case (op_q)
				OP_INSERT: begin
					ptr_q <= IDX_W'(cnt_w - CMP_W'(1));
					rem_q <= CNT_W'(cnt_w + CMP_W'(1) - pos_w);
				end
				OP_DELETE: begin
					ptr_q <= IDX_W'(pos_w);
					rem_q <= CNT_W'(cnt_w - pos_w);
				end
				default: begin
					ptr_q <= '0;
					rem_q <= count_q;
				end
			endcase
		end else if (cmd.scan_step) begin
			if (issue) begin
				ptr_q <= (op_q == OP_INSERT) ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
				rem_q <= rem_q - CNT_W'(1);
			end
			if (hit_now) begin
				hit_q   <= 1'b1;
				found_q <= POS_W'(CNT_W'(raddr_s1) + CNT_W'(1));
			end
		end
		// load the output register
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_rdval_q  <= rdval_q;
			out_found_q  <= found_q;
			out_len_q    <= POS_W'(count_q);
		end
	end

	assign status         = out_status_q;
	assign read_value     = out_rdval_q;
	assign found_position = out_found_q;
	assign list_length    = out_len_q;

endmodule

// ----- hdl/sle_ctrl.sv -----
// ---------------------------------------------------------------------------
// sle_ctrl: list engine controller
// Sequences one transaction at a time through decode, RAM read, scan and
// result hand-off, and owns the channel handshakes.
// ---------------------------------------------------------------------------
module sle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  sle_pkg::dp_stat_t stat,
	output sle_pkg::cmd_t     cmd
);
	import sle_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (stat.op)
					OP_GET: begin
						if (stat.pos_ok) begin
							state_d = S_READ;
						end
					end
					OP_LOCATE: state_d = S_SCAN;
					OP_INSERT: begin
						if (!stat.full && stat.ins_ok) begin
							state_d = S_SCAN;
						end
					end
					OP_DELETE: begin
						if (stat.pos_ok) begin
							state_d = S_SCAN;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_READ: state_d = S_DONE;
			S_SCAN: begin
				if (stat.scan_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		cmd.res_status = ST_OK;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_EXEC: begin
				cmd.res_init = 1'b1;
				unique case (stat.op)
					OP_CLEAR: cmd.clr_count = 1'b1;
					OP_APPEND: begin
						if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_tail = 1'b1;
						end
					end
					OP_GET: begin
						if (stat.pos_ok) begin
							cmd.rd_pos = 1'b1;
						end else begin
							cmd.res_status = ST_RANGE;
						end
					end
					OP_SET: begin
						if (stat.pos_ok) begin
							cmd.wr_pos = 1'b1;
						end else begin
							cmd.res_status = ST_RANGE;
						end
					end
					OP_LOCATE: cmd.scan_init = 1'b1;
					OP_INSERT: begin
						priority if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else if (!stat.ins_ok) begin
							cmd.res_status = ST_RANGE;
						end else begin
							cmd.scan_init = 1'b1;
						end
					end
					OP_DELETE: begin
						if (stat.pos_ok) begin
							cmd.scan_init = 1'b1;
						end else begin
							cmd.res_status = ST_RANGE;
						end
					end
					default: cmd.res_status = ST_OK;
				endcase
			end
			S_READ: cmd.cap_read = 1'b1;
			S_SCAN: begin
				cmd.scan_step = !stat.scan_end;
				cmd.scan_fin  = stat.scan_end;
			end
			S_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/sequential_list_engine_core.sv -----
// ---------------------------------------------------------------------------
// sequential_list_engine_core: ordered list of signed 32-bit values
// Each input transaction carries opcode, position and value; each one
// returns exactly one result: status, read_value, found_position and
// list_length. Positions are 1-based.
// Input channel: in_valid/in_stall; in_stall is high while a transaction is
// being worked on, one transaction at a time.
// Output channel: out_valid/out_stall through an output register; the next
// input transaction is taken while a result still waits there. If the
// receiver stalls, the result holds and the following transaction finishes
// its work and then waits for the output register.
// Clear, append, set, the unused opcode and refused operations pass through
// decode and the result hand-off; get adds a RAM read, and locate, insert
// and delete add a scan over the entries (up to DEPTH). The scan is set by the
// single read port of the element RAM, one entry per cycle. The next input
// transaction is taken in the cycle after the result is loaded.
// Reset: the list is empty and both channels are idle at once; no clearing
// pass runs. Element storage is not cleared and is only read once written.
// ---------------------------------------------------------------------------
module sequential_list_engine_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  sle_pkg::pos_t    position,
	input  sle_pkg::val_t    value,
	output logic             out_valid,
	input  logic             out_stall,
	output sle_pkg::status_t status,
	output sle_pkg::val_t    read_value,
	output sle_pkg::pos_t    found_position,
	output sle_pkg::pos_t    list_length
);
	import sle_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sle_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.position      (position),
		.value         (value),
		.status        (status),
		.read_value    (read_value),
		.found_position(found_position),
		.list_length   (list_length)
	);

endmodule

// ----- hdl/sle_checker.sv -----
// ---------------------------------------------------------------------------
// sle_checker: port-level checks for the list engine
// Watches the top-level channels and result fields over time.
// ---------------------------------------------------------------------------
module sle_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [2:0]       opcode,
	input sle_pkg::pos_t    position,
	input sle_pkg::val_t    value,
	input logic             out_valid,
	input logic             out_stall,
	input sle_pkg::status_t status,
	input sle_pkg::val_t    read_value,
	input sle_pkg::pos_t    found_position,
	input sle_pkg::pos_t    list_length
);
	import sle_pkg::*;

	// hold a stalled input transaction
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> $stable(opcode) && $stable(position) && $stable(value))
	else $error("stalled input changed");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(read_value) && $stable(found_position) && $stable(list_length))
	else $error("stalled result changed");

	// stall input after each accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input not stalled after accept");

	// a refused operation reports nothing else
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (read_value == '0) && (found_position == '0))
	else $error("refused operation carries data");

	// a locate hit never carries read data or an error status
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found_position != '0) |-> (read_value == '0) && (status == ST_OK))
	else $error("found position with read data or error");

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (.*);

// ----- tb/sv/sequential_list_engine_core_test.sv -----
// ---------------------------------------------------------------------------
// sequential_list_engine_core_test: self-checking bench for the list engine
// Keeps a shadow copy of the list and predicts one reply per accepted
// transaction. Each reply is compared field by field on the output channel.
// Runs directed corner cases, a fill to capacity, a long receiver hold-off,
// a drain pause, and biased random bursts under three idling profiles.
// ---------------------------------------------------------------------------
module sequential_list_engine_core_test;
	import sle_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int TOTAL_ITEMS = 1050;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;
	localparam val_t VAL_MIN = 32'sh8000_0000;
	localparam val_t VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		status_t status;
		val_t    read_value;
		pos_t    found_position;
		pos_t    list_length;
	} list_reply_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] opcode = 3'd0;
	pos_t       position = '0;
	val_t       value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	status_t    status;
	val_t       read_value;
	pos_t       found_position;
	pos_t       list_length;

	// Shadow list and replies still owed by the block
	val_t        shadow_list [DEPTH];
	int          shadow_len = 0;
	list_reply_t due_replies [$];

	int items_sent = 0;
	int failures = 0;
	int send_idle_pct = 30;
	int recv_stall_pct = 53;
	int holdoff_requests = 0;
	int holdoffs_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	val_t value_pool [16];

	sequential_list_engine_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one operation to the shadow list and return the reply it gives
	function automatic list_reply_t apply_list_op(input logic [2:0] op, input pos_t pos,
			input val_t v);
		list_reply_t r;
		int p;
		int j;
		bit in_range;
		p = pos;
		r.status = ST_OK;
		r.read_value = '0;
		r.found_position = '0;
		in_range = (p >= 1) && (p <= shadow_len);
		case (op)
			OP_CLEAR: shadow_len = 0;
			OP_APPEND: begin
				if (shadow_len >= DEPTH) r.status = ST_FULL;
				else begin
					shadow_list[shadow_len] = v;
					shadow_len++;
				end
			end
			OP_GET: begin
				if (in_range) r.read_value = shadow_list[p-1];
				else r.status = ST_RANGE;
			end
			OP_SET: begin
				if (in_range) shadow_list[p-1] = v;
				else r.status = ST_RANGE;
			end
			OP_LOCATE: begin
				for (j = 0; j < shadow_len; j++) begin
					if (shadow_list[j] == v) begin
						r.found_position = pos_t'(j + 1);
						break;
					end
				end
			end
			OP_INSERT: begin
				if (shadow_len >= DEPTH) r.status = ST_FULL;
				else if (p < 1 || p > shadow_len + 1) r.status = ST_RANGE;
				else begin
					for (j = shadow_len; j >= p; j--) shadow_list[j] = shadow_list[j-1];
					shadow_list[p-1] = v;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (in_range) begin
					for (j = p; j < shadow_len; j++) shadow_list[j-1] = shadow_list[j];
					shadow_len--;
				end else r.status = ST_RANGE;
			end
			default: ;
		endcase
		r.list_length = pos_t'(shadow_len);
		return r;
	endfunction

	task automatic report_failure(input string msg);
		if (failures < 10) $display("%0t: %s", $realtime, msg);
		failures++;
	endtask

	// Compare the accepted reply with the oldest prediction
	task automatic check_reply();
		list_reply_t want;
		if (due_replies.size() == 0) begin
			report_failure($sformatf("reply with none due: status %0d length %0d",
				status, list_length));
		end else begin
			want = due_replies.pop_front();
			if (status !== want.status || read_value !== want.read_value ||
					found_position !== want.found_position ||
					list_length !== want.list_length)
				report_failure($sformatf(
					"mismatch: exp st %0d rd %0d fp %0d len %0d, got st %0d rd %0d fp %0d len %0d",
					want.status, want.read_value, want.found_position, want.list_length,
					status, read_value, found_position, list_length));
		end
	endtask

	// Check replies, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) check_reply();
			if (holdoff_requests != holdoffs_taken) begin
				holdoffs_taken = holdoff_requests;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL sequential_list_engine_core");
			$finish;
		end
	end

	// Offer one transaction and predict its reply once accepted
	task automatic send_item(input logic [2:0] op, input pos_t pos, input val_t v);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		value <= v;
		do @(posedge clk); while (in_stall);
		due_replies.push_back(apply_list_op(op, pos, v));
		items_sent++;
	endtask

	// Hold the input idle until every reply has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_replies.size() != 0);
	endtask

	// Pick a mostly well-formed operation, growing the list toward a target
	task automatic random_op(input int target, input int grow_pct);
		logic [2:0] op;
		pos_t pos;
		val_t v;
		int r;
		r = $urandom_range(0, 99);
		if (shadow_len < target && r < grow_pct)
			op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
		else begin
			r = $urandom_range(0, 99);
			if (r < 2) op = OP_CLEAR;
			else if (r < 3) op = OP_UNUSED;
			else op = 3'($urandom_range(1, 6));
		end
		r = $urandom_range(0, 99);
		if (r < 12) pos = pos_t'($urandom_range(0, 255));
		else if (op == OP_INSERT) pos = pos_t'($urandom_range(1, shadow_len + 1));
		else if (shadow_len == 0) pos = pos_t'($urandom_range(0, 2));
		else pos = pos_t'($urandom_range(1, shadow_len));
		if ($urandom_range(0, 99) < 55) v = value_pool[$urandom_range(0, 15)];
		else v = val_t'($urandom);
		send_item(op, pos, v);
	endtask

	// Empty-list refusals, value extremes, both ends of get, insert and delete
	task automatic test_directed();
		send_item(OP_CLEAR, 8'd0, 32'sd0);
		send_item(OP_GET, 8'd1, 32'sd0);
		send_item(OP_DELETE, 8'd1, 32'sd0);
		send_item(OP_SET, 8'd1, 32'sd9);
		send_item(OP_LOCATE, 8'd0, 32'sd0);
		send_item(OP_UNUSED, 8'd255, VAL_MAX);
		send_item(OP_APPEND, 8'd0, VAL_MIN);
		send_item(OP_APPEND, 8'd255, VAL_MAX);
		send_item(OP_APPEND, 8'd0, -32'sd1);
		send_item(OP_APPEND, 8'd0, 32'sd0);
		send_item(OP_INSERT, 8'd1, 32'sd5);
		send_item(OP_INSERT, pos_t'(shadow_len + 1), VAL_MIN);
		send_item(OP_INSERT, pos_t'(shadow_len + 2), 32'sd7);
		send_item(OP_INSERT, 8'd0, 32'sd7);
		send_item(OP_GET, 8'd0, 32'sd0);
		send_item(OP_GET, 8'd1, 32'sd0);
		send_item(OP_GET, pos_t'(shadow_len), 32'sd0);
		send_item(OP_GET, pos_t'(shadow_len + 1), 32'sd0);
		send_item(OP_GET, 8'd255, 32'sd0);
		send_item(OP_SET, 8'd2, 32'sh5a5a_5a5a);
		send_item(OP_SET, 8'd255, 32'sd1);
		send_item(OP_LOCATE, 8'd0, VAL_MIN);
		send_item(OP_LOCATE, 8'd0, 32'sd12345);
		send_item(OP_DELETE, 8'd1, 32'sd0);
		send_item(OP_DELETE, pos_t'(shadow_len), 32'sd0);
		send_item(OP_DELETE, 8'd200, 32'sd0);
		send_item(OP_DELETE, 8'd0, 32'sd0);
	endtask

	// Fill to capacity, hit every full-list refusal, work at the top end
	task automatic test_fill_list();
		val_t last_val;
		send_item(OP_CLEAR, 8'd0, 32'sd0);
		repeat (DEPTH) begin
			last_val = val_t'($urandom);
			send_item(OP_APPEND, pos_t'($urandom_range(0, 255)), last_val);
		end
		send_item(OP_APPEND, 8'd1, VAL_MAX);
		send_item(OP_INSERT, 8'd0, VAL_MIN);
		send_item(OP_INSERT, 8'd1, VAL_MIN);
		send_item(OP_INSERT, 8'd255, VAL_MIN);
		send_item(OP_LOCATE, 8'd0, last_val);
		send_item(OP_GET, pos_t'(DEPTH), 32'sd0);
		send_item(OP_GET, pos_t'(DEPTH + 1), 32'sd0);
		send_item(OP_SET, pos_t'(DEPTH), VAL_MIN);
		send_item(OP_DELETE, pos_t'(DEPTH), 32'sd0);
		send_item(OP_INSERT, pos_t'(DEPTH), VAL_MAX);
		send_item(OP_DELETE, 8'd1, 32'sd0);
		send_item(OP_LOCATE, 8'd0, val_t'($urandom));
	endtask

	// Stall the output for a long stretch while input keeps coming
	task automatic test_receiver_holdoff();
		holdoff_requests++;
		repeat (12) random_op(16, 50);
		wait_drain();
	endtask

	// Pause the sender until all replies are back, several times
	task automatic test_drain_pause();
		repeat (4) begin
			repeat (5) random_op(8, 50);
			wait_drain();
		end
	endtask

	// Random bursts: mostly short lists, now and then a full one
	task automatic test_random(input int until_items, input int send_pct, input int recv_pct);
		int target;
		int burst_len;
		int grow_pct;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (items_sent < until_items) begin
			if ($urandom_range(0, 5) == 0) begin
				target = DEPTH;
				burst_len = 220;
				grow_pct = 75;
			end else begin
				target = $urandom_range(1, 24);
				burst_len = $urandom_range(20, 60);
				grow_pct = 40;
			end
			if ($urandom_range(0, 1))
				send_item(OP_CLEAR, pos_t'($urandom_range(0, 255)), val_t'($urandom));
			// stop the burst once the item budget is spent
			repeat (burst_len) if (items_sent < until_items) random_op(target, grow_pct);
			if ($urandom_range(0, 3) == 0) wait_drain();
		end
	endtask

	task automatic finish_run();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0) $display("PASS sequential_list_engine_core");
		else $display("FAIL sequential_list_engine_core");
		$finish;
	endtask

	initial begin
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = -32'sd1;
		value_pool[3] = 32'sd0;
		for (int i = 4; i < 16; i++) value_pool[i] = val_t'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_list();
		test_receiver_holdoff();
		test_random(450, 30, 53);
		test_random(750, 53, 30);
		test_drain_pause();
		test_random(TOTAL_ITEMS, 0, 0);
		finish_run();
	end

endmodule

// ----- sim.f -----
hdl/sle_pkg.sv
hdl/sle_ram.sv
hdl/sle_dp.sv
hdl/sle_ctrl.sv
hdl/sequential_list_engine_core.sv
hdl/sle_checker.sv
tb/sv/sequential_list_engine_core_test.sv
